>>> rtl/core/cda_pkg.sv
// Package with the sequencer states, month lengths and leap arithmetic constants.
package cda_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_SPLIT,
      ST_DOY,
      ST_WALK
   } state_type;

   localparam int DAY_WIDTH   = 5;
   localparam int MONTH_WIDTH = 4;
   localparam int YEAR_WIDTH  = 14;
   localparam int ADD_WIDTH   = 15;
   localparam int REM_WIDTH   = 16;
   localparam int LEN_WIDTH   = 5;

   localparam logic [MONTH_WIDTH-1:0] JANUARY  = 4'd1;
   localparam logic [MONTH_WIDTH-1:0] FEBRUARY = 4'd2;
   localparam logic [MONTH_WIDTH-1:0] DECEMBER = 4'd12;

   // Year / 100 is taken as (year * RECIP) >> RECIP_SHIFT, exact for all 14-bit years.
   localparam int RECIP_WIDTH = 13;
   localparam logic [RECIP_WIDTH-1:0] RECIP = 13'd5243;
   localparam int RECIP_SHIFT = 19;
   localparam int PROD_WIDTH  = YEAR_WIDTH + RECIP_WIDTH;
   localparam int CENT_WIDTH  = 8;
   localparam int LO_WIDTH    = 7;
   localparam logic [LO_WIDTH-1:0] CENTURY     = 7'd100;
   localparam logic [LO_WIDTH-1:0] LAST_IN_CEN = 7'd99;
   localparam logic [YEAR_WIDTH-1:0] YEAR_MAX  = 14'd16383;

   function automatic logic [LEN_WIDTH-1:0] month_len(input logic [MONTH_WIDTH-1:0] m,
                                                      input logic leap);
      logic [LEN_WIDTH-1:0] len;
      case (m)
         4'd1:    len = 5'd31;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd31;
         4'd4:    len = 5'd30;
         4'd5:    len = 5'd31;
         4'd6:    len = 5'd30;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd31;
         4'd9:    len = 5'd30;
         4'd10:   len = 5'd31;
         4'd11:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

>>> rtl/core/calendar_date_add_days.sv
// Top level of the Gregorian date adder with its add/subtract sequencer.
// The single adder first sums the lengths of the months before the start month, then peels
// month lengths off one per cycle until the remainder fits in the current month.
// Throughput: one transaction at a time; busy stays high until the result strobe.
// Reset is synchronous and returns the sequencer to idle with no result pending.
module calendar_date_add_days (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [cda_pkg::DAY_WIDTH-1:0]   req_start_day,
   input  logic [cda_pkg::MONTH_WIDTH-1:0] req_start_month,
   input  logic [cda_pkg::YEAR_WIDTH-1:0]  req_start_year,
   input  logic [cda_pkg::ADD_WIDTH-1:0]   req_days_to_add,
   output logic                           rsp_valid,
   output logic [cda_pkg::DAY_WIDTH-1:0]   rsp_result_day,
   output logic [cda_pkg::MONTH_WIDTH-1:0] rsp_result_month,
   output logic [cda_pkg::YEAR_WIDTH-1:0]  rsp_result_year
);

   cda_pkg::state_type state_ff, state_in;
   logic [cda_pkg::REM_WIDTH-1:0]   rem_ff, rem_in;
   logic [cda_pkg::MONTH_WIDTH-1:0] month_ff, month_in;
   logic [cda_pkg::MONTH_WIDTH-1:0] mcount_ff, mcount_in;
   logic [cda_pkg::YEAR_WIDTH-1:0]  year_ff, year_in;
   logic [cda_pkg::CENT_WIDTH-1:0]  cent_ff, cent_in;
   logic [cda_pkg::LO_WIDTH-1:0]    lo_ff, lo_in;
   logic [1:0]                     hi_ff, hi_in;
   logic                           valid_ff, valid_in;
   logic [cda_pkg::DAY_WIDTH-1:0]   out_day_ff, out_day_in;
   logic [cda_pkg::MONTH_WIDTH-1:0] out_month_ff, out_month_in;
   logic [cda_pkg::YEAR_WIDTH-1:0]  out_year_ff, out_year_in;

   logic                           leap;
   logic [cda_pkg::LEN_WIDTH-1:0]   len;
   logic                           alu_sub;
   logic [cda_pkg::REM_WIDTH-1:0]   alu_out;
   logic [cda_pkg::PROD_WIDTH-1:0]  prod;
   logic [cda_pkg::YEAR_WIDTH:0]    cent_x100;

   assign leap = ((year_ff[1:0] == 2'd0) && (lo_ff != '0)) || ((lo_ff == '0) && (hi_ff == 2'd0));
   assign len  = cda_pkg::month_len(mcount_ff, leap);
   assign alu_out = alu_sub ? (rem_ff - {{(cda_pkg::REM_WIDTH-cda_pkg::LEN_WIDTH){1'b0}}, len})
                            : (rem_ff + {{(cda_pkg::REM_WIDTH-cda_pkg::LEN_WIDTH){1'b0}}, len});
   assign prod = {{cda_pkg::RECIP_WIDTH{1'b0}}, year_ff} *
                 {{cda_pkg::YEAR_WIDTH{1'b0}}, cda_pkg::RECIP};
   assign cent_x100 = (cda_pkg::YEAR_WIDTH+1)'({{(cda_pkg::YEAR_WIDTH+1-cda_pkg::CENT_WIDTH){1'b0}},
                       cent_ff} * {{(cda_pkg::YEAR_WIDTH+1-cda_pkg::LO_WIDTH){1'b0}},
                       cda_pkg::CENTURY});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cda_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      rem_ff       <= rem_in;
      month_ff     <= month_in;
      mcount_ff    <= mcount_in;
      year_ff      <= year_in;
      cent_ff      <= cent_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      out_day_ff   <= out_day_in;
      out_month_ff <= out_month_in;
      out_year_ff  <= out_year_in;
   end

   always_comb begin
      state_in     = state_ff;
      rem_in       = rem_ff;
      month_in     = month_ff;
      mcount_in    = mcount_ff;
      year_in      = year_ff;
      cent_in      = cent_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      valid_in     = 1'b0;
      out_day_in   = out_day_ff;
      out_month_in = out_month_ff;
      out_year_in  = out_year_ff;
      alu_sub      = 1'b0;
      case (state_ff)
         cda_pkg::ST_IDLE: begin
            if (start) begin
               rem_in = {{(cda_pkg::REM_WIDTH-cda_pkg::DAY_WIDTH){1'b0}}, req_start_day} +
                        {{(cda_pkg::REM_WIDTH-cda_pkg::ADD_WIDTH){1'b0}}, req_days_to_add};
               if (req_start_month == '0) begin
                  month_in = cda_pkg::JANUARY;
               end else if (req_start_month > cda_pkg::DECEMBER) begin
                  month_in = cda_pkg::DECEMBER;
               end else begin
                  month_in = req_start_month;
               end
               mcount_in = cda_pkg::JANUARY;
               year_in   = req_start_year;
               state_in  = cda_pkg::ST_SCALE;
            end
         end
         cda_pkg::ST_SCALE: begin
            cent_in  = prod[cda_pkg::RECIP_SHIFT +: cda_pkg::CENT_WIDTH];
            state_in = cda_pkg::ST_SPLIT;
         end
         cda_pkg::ST_SPLIT: begin
            lo_in    = cda_pkg::LO_WIDTH'({1'b0, year_ff} - cent_x100);
            hi_in    = cent_ff[1:0];
            state_in = cda_pkg::ST_DOY;
         end
         cda_pkg::ST_DOY: begin
            if (mcount_ff < month_ff) begin
               rem_in    = alu_out;
               mcount_in = mcount_ff + 1'b1;
            end else begin
               mcount_in = cda_pkg::JANUARY;
               state_in  = cda_pkg::ST_WALK;
            end
         end
         cda_pkg::ST_WALK: begin
            alu_sub = 1'b1;
            if (rem_ff > {{(cda_pkg::REM_WIDTH-cda_pkg::LEN_WIDTH){1'b0}}, len}) begin
               rem_in = alu_out;
               if (mcount_ff == cda_pkg::DECEMBER) begin
                  mcount_in = cda_pkg::JANUARY;
                  year_in   = year_ff + 1'b1;
                  if (year_ff == cda_pkg::YEAR_MAX) begin
                     lo_in = '0;
                     hi_in = 2'd0;
                  end else if (lo_ff == cda_pkg::LAST_IN_CEN) begin
                     lo_in = '0;
                     hi_in = hi_ff + 1'b1;
                  end else begin
                     lo_in = lo_ff + 1'b1;
                  end
               end else begin
                  mcount_in = mcount_ff + 1'b1;
               end
            end else begin
               out_day_in   = rem_ff[cda_pkg::DAY_WIDTH-1:0];
               out_month_in = mcount_ff;
               out_year_in  = year_ff;
               valid_in     = 1'b1;
               state_in     = cda_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cda_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy             = (state_ff != cda_pkg::ST_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_result_day   = out_day_ff;
   assign rsp_result_month = out_month_ff;
   assign rsp_result_year  = out_year_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted transaction did not make the block busy.");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("Result strobe while a transaction is still in progress.");

   a_strobe_from_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == cda_pkg::ST_WALK))
      else $error("Result strobe not preceded by the month walk.");

   a_month_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cda_pkg::ST_WALK) |-> (mcount_ff >= cda_pkg::JANUARY &&
                                          mcount_ff <= cda_pkg::DECEMBER))
      else $error("Month counter left the calendar range during the walk.");

   a_lo_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cda_pkg::ST_WALK) |-> (lo_ff <= cda_pkg::LAST_IN_CEN))
      else $error("Year within century out of range.");

endmodule
